[design/i2cmbe_pkg.sv]
// i2cmbe_pkg: types and constants of the i2c master byte engine
// used by the channel interfaces, the engine and the top level
`timescale 1ns / 1ps
`default_nettype none
package i2cmbe_pkg;

	localparam int TICK_W = 5;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_LOW_SETUP = 2'd0,
		PH_HIGH      = 2'd1,
		PH_LOW_HOLD  = 2'd2
	} phase_t;

	localparam logic [TICK_W-1:0] START_LAST_TICK = TICK_W'(2);
	localparam logic [TICK_W-1:0] STOP_LAST_TICK  = TICK_W'(1);
	localparam logic [TICK_W-1:0] WR_DATA_TICKS   = TICK_W'(24);
	localparam logic [TICK_W-1:0] WR_ACK_TICK     = TICK_W'(25);
	localparam logic [TICK_W-1:0] WR_LAST_TICK    = TICK_W'(26);
	localparam logic [TICK_W-1:0] RD_LAST_TICK    = TICK_W'(15);

	typedef struct packed {
		logic              cmd_valid;
		logic [1:0]        req_type;
		logic [BYTE_W-1:0] tx_byte;
		logic              sda_in;
	} cmd_beat_t;

	typedef struct packed {
		logic              scl_out;
		logic              sda_out;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_bit;
	} res_beat_t;

endpackage
`default_nettype wire

[design/i2cmbe_if.sv]
// i2cmbe_cmd_if / i2cmbe_res_if: valid-ready channels of the engine
// payload widths from i2cmbe_pkg
`timescale 1ns / 1ps
`default_nettype none
interface i2cmbe_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd_valid;
	logic [1:0]                    req_type;
	logic [i2cmbe_pkg::BYTE_W-1:0] tx_byte;
	logic                          sda_in;

	modport source (output valid, cmd_valid, req_type, tx_byte, sda_in, input ready);
	modport sink (input valid, cmd_valid, req_type, tx_byte, sda_in, output ready);
endinterface

interface i2cmbe_res_if;
	logic                          valid;
	logic                          ready;
	logic                          scl_out;
	logic                          sda_out;
	logic                          busy_res;
	logic                          done_res;
	logic [i2cmbe_pkg::BYTE_W-1:0] rx_byte;
	logic                          ack_bit;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
		input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
		output ready);
endinterface
`default_nettype wire

[design/i2cmbe_engine.sv]
// i2cmbe_engine: bus sequencer state and one-tick next-state logic
// depends on i2cmbe_pkg
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_engine (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire i2cmbe_pkg::cmd_beat_t beat,
	output i2cmbe_pkg::res_beat_t      result
);

	logic [i2cmbe_pkg::TICK_W-1:0] tick_q, tick_n, t;
	i2cmbe_pkg::req_t              cmd_q, cmd;
	i2cmbe_pkg::phase_t            ph_q, ph_n, ph;
	logic                          busy_q, busy;
	logic [i2cmbe_pkg::BYTE_W-1:0] send_q, send_n;
	logic [i2cmbe_pkg::BYTE_W-1:0] recv_q, recv_n;
	logic                          ack_q, ack_n;
	logic                          scl_q, scl_n;
	logic                          sda_q, sda_n;
	logic                          take;
	logic                          fin;

	always_comb begin
		take   = !busy_q && beat.cmd_valid;
		cmd    = take ? i2cmbe_pkg::req_t'(beat.req_type) : cmd_q;
		t      = take ? '0 : tick_q;
		ph     = take ? i2cmbe_pkg::PH_LOW_SETUP : ph_q;
		busy   = busy_q || take;
		send_n = (take && cmd == i2cmbe_pkg::REQ_WRITE) ? beat.tx_byte : send_q;
		recv_n = (take && cmd == i2cmbe_pkg::REQ_READ) ? '0 : recv_q;
		ack_n  = ack_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		ph_n   = ph;
		fin    = 1'b0;
		if (busy) begin
			case (cmd)
				i2cmbe_pkg::REQ_START: begin
					scl_n = (t != i2cmbe_pkg::START_LAST_TICK);
					sda_n = (t == '0);
					fin   = (t == i2cmbe_pkg::START_LAST_TICK);
				end
				i2cmbe_pkg::REQ_STOP: begin
					scl_n = 1'b1;
					sda_n = (t == i2cmbe_pkg::STOP_LAST_TICK);
					fin   = (t == i2cmbe_pkg::STOP_LAST_TICK);
				end
				i2cmbe_pkg::REQ_WRITE: begin
					if (t < i2cmbe_pkg::WR_DATA_TICKS) begin
						sda_n = send_n[i2cmbe_pkg::BYTE_W-1];
						scl_n = (ph == i2cmbe_pkg::PH_HIGH);
						case (ph)
							i2cmbe_pkg::PH_LOW_SETUP: ph_n = i2cmbe_pkg::PH_HIGH;
							i2cmbe_pkg::PH_HIGH:      ph_n = i2cmbe_pkg::PH_LOW_HOLD;
							default: begin
								ph_n   = i2cmbe_pkg::PH_LOW_SETUP;
								send_n = {send_n[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
							end
						endcase
					end else if (t == i2cmbe_pkg::WR_ACK_TICK) begin
						scl_n = 1'b1;
						sda_n = 1'b1;
						ack_n = beat.sda_in;
					end else begin
						scl_n = 1'b0;
						sda_n = 1'b1;
						fin   = (t != i2cmbe_pkg::WR_DATA_TICKS);
					end
				end
				default: begin
					sda_n = 1'b1;
					if (!t[0]) begin
						scl_n  = 1'b1;
						recv_n = {recv_n[i2cmbe_pkg::BYTE_W-2:0], beat.sda_in};
					end else begin
						scl_n = 1'b0;
						fin   = (t >= i2cmbe_pkg::RD_LAST_TICK);
					end
				end
			endcase
		end
		tick_n = (!busy || fin) ? '0 : t + 1'b1;

		result.scl_out  = scl_n;
		result.sda_out  = sda_n;
		result.busy_res = busy;
		result.done_res = busy && fin;
		result.rx_byte  = recv_n;
		result.ack_bit  = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			cmd_q  <= i2cmbe_pkg::REQ_START;
			ph_q   <= i2cmbe_pkg::PH_LOW_SETUP;
			busy_q <= 1'b0;
			send_q <= '0;
			recv_q <= '0;
			ack_q  <= 1'b1;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (step) begin
			tick_q <= tick_n;
			cmd_q  <= cmd;
			ph_q   <= ph_n;
			busy_q <= busy && !fin;
			send_q <= send_n;
			recv_q <= recv_n;
			ack_q  <= ack_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
		end
	end

	// idle sequencer sits at tick zero
	a_idle_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> tick_q == '0)
		else $error("tick counter running while idle");

	// no command runs past the acknowledge release tick
	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= i2cmbe_pkg::WR_LAST_TICK)
		else $error("tick counter beyond longest command");

	// the bit phase only moves during a write
	a_phase_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cmd_q != i2cmbe_pkg::REQ_WRITE) |-> ph_q == i2cmbe_pkg::PH_LOW_SETUP)
		else $error("bit phase moved outside a write");

	// a finishing beat that is stepped drops busy
	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.done_res) |=> !busy_q)
		else $error("busy held after done");

endmodule
`default_nettype wire

[design/i2c_master_byte_engine_core.sv]
// i2c_master_byte_engine_core: top level with input and result registers
// depends on i2cmbe_pkg, i2cmbe_if and i2cmbe_engine
`timescale 1ns / 1ps
`default_nettype none
// Each command beat is one bus time-base tick and yields exactly one result beat
// with the SCL/SDA levels for that tick. One tick is processed per clock cycle
// while the result side is not stalled; a beat passes an input register, then
// the sequencer logic into the result register that offers it. A beat
// leaves the input register whenever the result register is empty or being
// read in the same cycle, so the command side stays ready while results flow.
// cmd_valid is only looked at while the engine is idle; start lasts 3 ticks,
// stop 2, write byte 27 and read byte 16.
module i2c_master_byte_engine_core (
	input wire logic    clk,
	input wire logic    arst_n,
	i2cmbe_cmd_if.sink  cmd,
	i2cmbe_res_if.source res
);

	logic                  valid_s1;
	i2cmbe_pkg::cmd_beat_t beat_s1;
	logic                  valid_s2;
	i2cmbe_pkg::res_beat_t res_s2;
	i2cmbe_pkg::res_beat_t result;
	logic                  advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			beat_s1.cmd_valid <= cmd.cmd_valid;
			beat_s1.req_type  <= cmd.req_type;
			beat_s1.tx_byte   <= cmd.tx_byte;
			beat_s1.sda_in    <= cmd.sda_in;
		end
	end

	i2cmbe_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign res.valid    = valid_s2;
	assign res.scl_out  = res_s2.scl_out;
	assign res.sda_out  = res_s2.sda_out;
	assign res.busy_res = res_s2.busy_res;
	assign res.done_res = res_s2.done_res;
	assign res.rx_byte  = res_s2.rx_byte;
	assign res.ack_bit  = res_s2.ack_bit;

endmodule
`default_nettype wire

[verif/i2cmbe_level_checker.sv]
// i2cmbe_level_checker: watches the command and result channels of the byte engine,
// predicts the bus levels and status of every accepted tick and compares them in order
// depends on i2cmbe_pkg and the channel interfaces in i2cmbe_if
`timescale 1ns / 1ps
module i2cmbe_level_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	i2cmbe_cmd_if     cmd,
	i2cmbe_res_if     res,
	output int        mismatches,
	output int        outstanding
);
	import i2cmbe_pkg::*;

	logic              eng_busy;
	req_t              eng_cmd;
	logic [TICK_W-1:0] eng_tick;
	logic [BYTE_W-1:0] eng_tx;
	logic [BYTE_W-1:0] eng_rx;
	logic              eng_ack;
	logic              eng_scl;
	logic              eng_sda;

	res_beat_t expected_levels[$];
	res_beat_t got_beat;
	res_beat_t want_beat;

	function automatic res_beat_t next_bus_levels(input cmd_beat_t b);
		res_beat_t r;
		logic      fin;
		phase_t    ph;
		r = '0;
		fin = 1'b0;
		if (!eng_busy && b.cmd_valid) begin
			eng_busy = 1'b1;
			eng_cmd = req_t'(b.req_type);
			eng_tick = '0;
			if (eng_cmd == REQ_WRITE)
				eng_tx = b.tx_byte;
			if (eng_cmd == REQ_READ)
				eng_rx = '0;
		end
		if (eng_busy) begin
			r.busy_res = 1'b1;
			case (eng_cmd)
				REQ_START: begin
					if (eng_tick == 0) begin
						eng_scl = 1'b1;
						eng_sda = 1'b1;
					end else if (eng_tick == 1) begin
						eng_scl = 1'b1;
						eng_sda = 1'b0;
					end else begin
						eng_scl = 1'b0;
						eng_sda = 1'b0;
						fin = 1'b1;
					end
				end
				REQ_STOP: begin
					eng_scl = 1'b1;
					if (eng_tick == 0) begin
						eng_sda = 1'b0;
					end else begin
						eng_sda = 1'b1;
						fin = 1'b1;
					end
				end
				REQ_WRITE: begin
					if (eng_tick < WR_DATA_TICKS) begin
						ph = phase_t'(eng_tick % 3);
						eng_sda = eng_tx[BYTE_W-1];
						eng_scl = (ph == PH_HIGH);
						if (ph == PH_LOW_HOLD)
							eng_tx = {eng_tx[BYTE_W-2:0], 1'b0};
					end else if (eng_tick == WR_DATA_TICKS) begin
						eng_scl = 1'b0;
						eng_sda = 1'b1;
					end else if (eng_tick == WR_ACK_TICK) begin
						eng_scl = 1'b1;
						eng_sda = 1'b1;
						eng_ack = b.sda_in;
					end else begin
						eng_scl = 1'b0;
						eng_sda = 1'b1;
						fin = 1'b1;
					end
				end
				default: begin
					eng_sda = 1'b1;
					if (!eng_tick[0]) begin
						eng_scl = 1'b1;
						eng_rx = {eng_rx[BYTE_W-2:0], b.sda_in};
					end else begin
						eng_scl = 1'b0;
						if (eng_tick >= RD_LAST_TICK)
							fin = 1'b1;
					end
				end
			endcase
			if (fin) begin
				r.done_res = 1'b1;
				eng_busy = 1'b0;
				eng_tick = '0;
			end else begin
				eng_tick = eng_tick + 1'b1;
			end
		end
		r.scl_out = eng_scl;
		r.sda_out = eng_sda;
		r.rx_byte = eng_rx;
		r.ack_bit = eng_ack;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_busy = 1'b0;
			eng_cmd = REQ_START;
			eng_tick = '0;
			eng_tx = '0;
			eng_rx = '0;
			eng_ack = 1'b1;
			eng_scl = 1'b1;
			eng_sda = 1'b1;
			expected_levels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (res.valid && res.ready) begin
				got_beat = '{res.scl_out, res.sda_out, res.busy_res, res.done_res,
					res.rx_byte, res.ack_bit};
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with no tick outstanding: scl %b sda %b busy %b done %b rx %h ack %b",
							$realtime, got_beat.scl_out, got_beat.sda_out, got_beat.busy_res,
							got_beat.done_res, got_beat.rx_byte, got_beat.ack_bit);
				end else begin
					want_beat = expected_levels.pop_front();
					if (got_beat.scl_out !== want_beat.scl_out
						|| got_beat.sda_out !== want_beat.sda_out
						|| got_beat.busy_res !== want_beat.busy_res
						|| got_beat.done_res !== want_beat.done_res
						|| got_beat.rx_byte !== want_beat.rx_byte
						|| got_beat.ack_bit !== want_beat.ack_bit) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: tick levels wrong: expected scl %b sda %b busy %b done %b rx %h ack %b, got scl %b sda %b busy %b done %b rx %h ack %b",
								$realtime, want_beat.scl_out, want_beat.sda_out,
								want_beat.busy_res, want_beat.done_res, want_beat.rx_byte,
								want_beat.ack_bit, got_beat.scl_out, got_beat.sda_out,
								got_beat.busy_res, got_beat.done_res, got_beat.rx_byte,
								got_beat.ack_bit);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				expected_levels.push_back(next_bus_levels('{cmd.cmd_valid, cmd.req_type,
					cmd.tx_byte, cmd.sda_in}));
			outstanding = expected_levels.size();
		end
	end

endmodule

[verif/i2c_master_byte_engine_core_test.sv]
// i2c_master_byte_engine_core_test: clock, reset and tick stimulus for the byte engine,
// with random stalls on both channels; the verdict comes from i2cmbe_level_checker
// depends on i2cmbe_pkg, i2cmbe_if, the engine top level and the checker
`timescale 1ns / 1ps
module i2c_master_byte_engine_core_test;

	typedef enum int {
		BUSY_QUIET,
		BUSY_NOISE,
		BUSY_PUSH
	} busy_stim_t;

	logic clk;
	logic arst_n;
	int   snd_idle_pct = 30;
	int   rcv_idle_pct = 50;
	int   beats_sent = 0;
	int   phase_end;
	int   mismatches;
	int   outstanding;

	i2cmbe_cmd_if cmd_ch ();
	i2cmbe_res_if res_ch ();

	i2c_master_byte_engine_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	i2cmbe_level_checker levels_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// one bus tick per beat, with random gaps carrying junk payload
	task automatic put_tick(input logic cv, input logic [1:0] rq, input logic [7:0] tx,
		input logic sd);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_ch.valid = 1'b0;
			cmd_ch.cmd_valid = 1'($urandom_range(1));
			cmd_ch.req_type = 2'($urandom_range(3));
			cmd_ch.tx_byte = 8'($urandom_range(255));
			cmd_ch.sda_in = 1'($urandom_range(1));
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.cmd_valid = cv;
		cmd_ch.req_type = rq;
		cmd_ch.tx_byte = tx;
		cmd_ch.sda_in = sd;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic idle_tick();
		put_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
			1'($urandom_range(1)));
	endtask

	// sda_seq bit k is the bus data level seen on tick k of the command
	task automatic run_command(input i2cmbe_pkg::req_t rq, input logic [7:0] tx,
		input logic [31:0] sda_seq, input busy_stim_t mode);
		int ticks;
		case (rq)
			i2cmbe_pkg::REQ_START: ticks = i2cmbe_pkg::START_LAST_TICK + 1;
			i2cmbe_pkg::REQ_STOP:  ticks = i2cmbe_pkg::STOP_LAST_TICK + 1;
			i2cmbe_pkg::REQ_WRITE: ticks = i2cmbe_pkg::WR_LAST_TICK + 1;
			default:               ticks = i2cmbe_pkg::RD_LAST_TICK + 1;
		endcase
		put_tick(1'b1, rq, tx, sda_seq[0]);
		for (int k = 1; k < ticks; k++) begin
			case (mode)
				BUSY_QUIET: put_tick(1'b0, rq, tx, sda_seq[k]);
				BUSY_NOISE: put_tick(1'($urandom_range(1)), 2'($urandom_range(3)),
					8'($urandom_range(255)), sda_seq[k]);
				default:    put_tick(1'b1, 2'($urandom_range(3)), 8'($urandom_range(255)),
					sda_seq[k]);
			endcase
		end
	endtask

	// data levels that a slave would present for a read of the given byte
	function automatic logic [31:0] read_pattern(input logic [7:0] v);
		logic [31:0] p;
		p = $urandom;
		for (int i = 0; i < 8; i++)
			p[2*i] = v[7-i];
		return p;
	endfunction

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd_valid = 1'b0;
		cmd_ch.req_type = i2cmbe_pkg::REQ_START;
		cmd_ch.tx_byte = '0;
		cmd_ch.sda_in = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_tick();
		idle_tick();
		run_command(i2cmbe_pkg::REQ_START, 8'h00, 32'h0, BUSY_QUIET);
		run_command(i2cmbe_pkg::REQ_WRITE, 8'h00, 32'h0, BUSY_QUIET);
		run_command(i2cmbe_pkg::REQ_WRITE, 8'hFF, 32'hFFFF_FFFF, BUSY_PUSH);
		run_command(i2cmbe_pkg::REQ_WRITE, 8'hA5, 32'h0, BUSY_NOISE);
		run_command(i2cmbe_pkg::REQ_WRITE, 8'h80, $urandom, BUSY_NOISE);
		run_command(i2cmbe_pkg::REQ_READ, 8'h00, read_pattern(8'hFF), BUSY_QUIET);
		run_command(i2cmbe_pkg::REQ_READ, 8'hFF, read_pattern(8'h00), BUSY_PUSH);
		run_command(i2cmbe_pkg::REQ_READ, 8'($urandom_range(255)), read_pattern(8'h5A),
			BUSY_NOISE);
		run_command(i2cmbe_pkg::REQ_STOP, 8'h00, 32'h0, BUSY_QUIET);
		idle_tick();
		run_command(i2cmbe_pkg::REQ_STOP, 8'hFF, 32'hFFFF_FFFF, BUSY_PUSH);
		run_command(i2cmbe_pkg::REQ_START, 8'hFF, 32'hFFFF_FFFF, BUSY_PUSH);
		run_command(i2cmbe_pkg::REQ_READ, 8'h00, read_pattern(8'hA5), BUSY_QUIET);
		idle_tick();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					snd_idle_pct = 30;
					rcv_idle_pct = 50;
				end
				1: begin
					snd_idle_pct = 50;
					rcv_idle_pct = 30;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			phase_end = beats_sent + 165;
			while (beats_sent < phase_end) begin
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(3, 1)) idle_tick();
				run_command(i2cmbe_pkg::req_t'($urandom_range(3)), 8'($urandom_range(255)),
					$urandom, busy_stim_t'($urandom_range(2)));
			end
		end

		cmd_ch.valid = 1'b0;
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
